### rtl/assert_macros.svh
// Assertion macros for the decimal ASCII emitter, included by its top-level RTL file.
// Stand-alone header; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DAE_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define DAE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define DAE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DAE_ASSERT(lbl, clk, rstn, prop, msg)
`define DAE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DAE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

### rtl/dae_pkg.sv
// Package for the decimal ASCII emitter: widths, constants and state types.
// No dependencies; used by every module of the block.
package dae_pkg;

	localparam int MAX_DIGITS_DEF  = 5;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int VALUE_W  = 15;
	localparam int S_DATA_W = 16;
	localparam int DIGIT_W  = 4;
	localparam int CHAR_W   = 6;
	localparam int M_DATA_W = 8;

	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	// Division by ten as multiply and shift; exact for inputs below 81920.
	localparam int                DIV10_W     = 16;
	localparam logic [DIV10_W-1:0] DIV10_MUL  = 16'd52429;
	localparam int                DIV10_SHIFT = 19;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_CONV,
		FR_PUSH
	} front_state_t;

endpackage

### rtl/decimal_ascii_emitter_top.sv
// The digit loop in the front end divides by ten once a cycle; the digit set then
// passes the push state, the queue and the emitter's digit and output registers.
// A new number is taken only while the front end is idle or its digit set leaves;
// the emitter sends one digit word per cycle from the queue while m_tready is high.
// Reset: arst_n clears the front state, the queue and the output valid at once.
`include "assert_macros.svh"
module decimal_ascii_emitter_top #(
	parameter int MAX_DIGITS  = dae_pkg::MAX_DIGITS_DEF,
	parameter int QUEUE_DEPTH = dae_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dae_pkg::S_DATA_W-1:0]   s_tdata,  // [14:0] value
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dae_pkg::M_DATA_W-1:0]   m_tdata,  // [5:0] digit_char
	output logic                           m_tlast   // last_digit
);

	localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int PKT_W = MAX_DIGITS * dae_pkg::DIGIT_W + IDX_W;

	logic                                        push_valid, push_ready;
	logic [MAX_DIGITS-1:0][dae_pkg::DIGIT_W-1:0] push_digits;
	logic [IDX_W-1:0]                            push_last_idx;
	logic                                        pop_valid, pop_ready;
	logic [PKT_W-1:0]                            pop_data;
	logic [MAX_DIGITS-1:0][dae_pkg::DIGIT_W-1:0] pop_digits;
	logic [IDX_W-1:0]                            pop_last_idx;
	logic [dae_pkg::CHAR_W-1:0]                  out_char;
	logic                                        char_ok;
	logic                                        s_take;
	logic                                        m_take_mid;

	assign pop_digits   = pop_data[PKT_W-1:IDX_W];
	assign pop_last_idx = pop_data[IDX_W-1:0];
	assign m_tdata      = {{(dae_pkg::M_DATA_W - dae_pkg::CHAR_W){1'b0}}, out_char};

	assign char_ok    = (m_tdata[dae_pkg::M_DATA_W-1:dae_pkg::CHAR_W] == '0)
		&& (out_char >= dae_pkg::ASCII_ZERO)
		&& (out_char <= dae_pkg::ASCII_ZERO + dae_pkg::CHAR_W'(9));
	assign s_take     = s_tvalid && s_tready;
	assign m_take_mid = m_tvalid && m_tready && !m_tlast;

	dae_front #(
		.MAX_DIGITS (MAX_DIGITS),
		.IDX_W      (IDX_W)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.value         (s_tdata[dae_pkg::VALUE_W-1:0]),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_digits   (push_digits),
		.push_last_idx (push_last_idx)
	);

	dae_queue #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W (PKT_W)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  ({push_digits, push_last_idx}),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_data)
	);

	dae_back #(
		.MAX_DIGITS (MAX_DIGITS),
		.IDX_W      (IDX_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_valid    (pop_valid),
		.pop_ready    (pop_ready),
		.pop_digits   (pop_digits),
		.pop_last_idx (pop_last_idx),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_char     (out_char),
		.out_last     (m_tlast)
	);

	// An outgoing word always carries an ASCII code from '0' to '9'.
	`DAE_ASSERT_IMP(a_char_range, clk, arst_n, m_tvalid, char_ok, "digit word out of range")
	// The front end enters the digit loop after a word, so it is not ready in the next cycle.
	`DAE_ASSERT_NXT(a_front_busy, clk, arst_n, s_take, !s_tready, "input taken back to back")
	// Inside a run the next digit follows without a gap.
	`DAE_ASSERT_NXT(a_run_gapless, clk, arst_n, m_take_mid, m_tvalid, "gap inside a digit run")

endmodule

### rtl/dae_front.sv
// Front end: accepts a number and splits it into decimal digits, one per cycle.
// Depends on dae_pkg; hands finished digit sets to the queue.
module dae_front #(
	parameter int MAX_DIGITS = dae_pkg::MAX_DIGITS_DEF,
	parameter int IDX_W      = 3
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [dae_pkg::VALUE_W-1:0]           value,
	output logic                                  push_valid,
	input  logic                                  push_ready,
	output logic [MAX_DIGITS-1:0][dae_pkg::DIGIT_W-1:0] push_digits,
	output logic [IDX_W-1:0]                      push_last_idx
);

	localparam int PROD_W = dae_pkg::VALUE_W + dae_pkg::DIV10_W;

	dae_pkg::front_state_t state_q, state_d;

	logic [dae_pkg::VALUE_W-1:0]                 rest_q;
	logic [IDX_W-1:0]                            cnt_q;
	logic [IDX_W-1:0]                            last_q;
	logic [MAX_DIGITS-1:0][dae_pkg::DIGIT_W-1:0] dig_q;

	logic [PROD_W-1:0]            prod;
	logic [dae_pkg::VALUE_W-1:0]  quot;
	logic [dae_pkg::VALUE_W+2:0]  quot10;
	logic [dae_pkg::DIGIT_W-1:0]  rem;
	logic                         conv_done;
	logic                         accept;

	assign prod      = PROD_W'(rest_q) * PROD_W'(dae_pkg::DIV10_MUL);
	assign quot      = dae_pkg::VALUE_W'(prod >> dae_pkg::DIV10_SHIFT);
	assign quot10    = {quot, 3'b000} + {2'b00, quot, 1'b0};
	assign rem       = dae_pkg::DIGIT_W'({3'b000, rest_q} - quot10);
	assign conv_done = (quot == '0) || (cnt_q == IDX_W'(MAX_DIGITS - 1));
	assign accept    = in_valid && in_ready;

	assign push_digits   = dig_q;
	assign push_last_idx = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dae_pkg::FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			dae_pkg::FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = dae_pkg::FR_CONV;
				end
			end
			dae_pkg::FR_CONV: begin
				if (conv_done) begin
					state_d = dae_pkg::FR_PUSH;
				end
			end
			dae_pkg::FR_PUSH: begin
				push_valid = 1'b1;
				// A new number may enter in the same cycle the digit set leaves.
				in_ready   = push_ready;
				if (push_ready) begin
					state_d = in_valid ? dae_pkg::FR_CONV : dae_pkg::FR_IDLE;
				end
			end
			default: begin
				state_d = dae_pkg::FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rest_q <= value;
			cnt_q  <= '0;
		end else if (state_q == dae_pkg::FR_CONV) begin
			dig_q[cnt_q] <= rem;
			rest_q       <= quot;
			if (conv_done) begin
				last_q <= cnt_q;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

### rtl/dae_queue.sv
// Short queue of digit sets between the front end and the emitter.
// Depends on dae_pkg only for the default of DEPTH.
module dae_queue #(
	parameter int DEPTH  = dae_pkg::QUEUE_DEPTH_DEF,
	parameter int DATA_W = 23
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_valid,
	output logic              wr_ready,
	input  logic [DATA_W-1:0] wr_data,
	output logic              rd_valid,
	input  logic              rd_ready,
	output logic [DATA_W-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  fill_q;
	logic              do_wr, do_rd;

	assign wr_ready = (fill_q != CNT_W'(DEPTH));
	assign rd_valid = (fill_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

### rtl/dae_back.sv
// Emitter: takes digit sets from the queue and sends them out as ASCII words,
// most significant digit first. Depends on dae_pkg.
module dae_back #(
	parameter int MAX_DIGITS = dae_pkg::MAX_DIGITS_DEF,
	parameter int IDX_W      = 3
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        pop_valid,
	output logic                                        pop_ready,
	input  logic [MAX_DIGITS-1:0][dae_pkg::DIGIT_W-1:0] pop_digits,
	input  logic [IDX_W-1:0]                            pop_last_idx,
	output logic                                        out_valid,
	input  logic                                        out_ready,
	output logic [dae_pkg::CHAR_W-1:0]                  out_char,
	output logic                                        out_last
);

	logic [MAX_DIGITS-1:0][dae_pkg::DIGIT_W-1:0] dig_q;
	logic [IDX_W-1:0]                            idx_q;
	logic                                        act_q;
	logic                                        val_q;
	logic [dae_pkg::CHAR_W-1:0]                  char_q;
	logic                                        last_q;
	logic                                        out_free;
	logic                                        emit;
	logic                                        final_emit;

	assign out_free   = !val_q || out_ready;
	assign emit       = act_q && out_free;
	assign final_emit = emit && (idx_q == '0);
	// The next digit set is taken while the last digit of this one goes out.
	assign pop_ready  = !act_q || final_emit;

	assign out_valid = val_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			val_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				act_q <= 1'b1;
			end else if (final_emit) begin
				act_q <= 1'b0;
			end
			if (emit) begin
				val_q <= 1'b1;
			end else if (out_ready) begin
				val_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= dae_pkg::ASCII_ZERO + dae_pkg::CHAR_W'(dig_q[idx_q]);
			last_q <= (idx_q == '0);
		end
		if (pop_valid && pop_ready) begin
			dig_q <= pop_digits;
			idx_q <= pop_last_idx;
		end else if (emit && (idx_q != '0)) begin
			idx_q <= idx_q - 1'b1;
		end
	end

endmodule
